// ----- sv/lmtk_pkg.sv -----
package lmtk_pkg;

    localparam int LIST_DEPTH  = 8;
    localparam int MAX_SAMPLES = 1024;

    localparam int COST_W  = 24;
    localparam int INDEX_W = 10;
    localparam int RANK_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int FILL_W  = $clog2(LIST_DEPTH + 1);
    localparam int SCAN_W  = $clog2(MAX_SAMPLES + 1);

    localparam logic [COST_W-1:0] CEILING_RESET = {COST_W{1'b1}};

    typedef struct packed {
        logic [COST_W-1:0]  sample_cost;
        logic [INDEX_W-1:0] sample_index;
        logic               sample_present;
        logic               stream_end;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] candidate_sample;
        logic [2:0]         candidate_rank;
        logic [3:0]         candidate_count;
        logic               run_last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic take_sample;
        logic close_scan;
        logic emit_next;
        logic clear_scan;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sample_room;
        logic emit_last;
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CLOSE = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

endpackage

// ----- sv/lmtk_ctrl.sv -----
module lmtk_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    input  logic              sample_present,
    input  logic              stream_end,
    output logic              sample_stall,
    output logic              result_valid,
    input  logic              result_stall,
    input  lmtk_pkg::status_t status,
    output lmtk_pkg::cmd_t    cmd
);

    lmtk_pkg::state_t state_reg;
    lmtk_pkg::state_t state_next;
    logic             accept;

    assign accept       = sample_valid && (state_reg == lmtk_pkg::ST_IDLE);
    assign sample_stall = (state_reg != lmtk_pkg::ST_IDLE);
    assign result_valid = (state_reg == lmtk_pkg::ST_EMIT);

    always_comb
    begin
        cmd.take_sample = accept && sample_present && status.sample_room;
        cmd.close_scan  = (state_reg == lmtk_pkg::ST_CLOSE);
        cmd.emit_next   = result_valid && !result_stall;
        cmd.clear_scan  = cmd.emit_next && status.emit_last;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lmtk_pkg::ST_IDLE:
            begin
                if (accept && stream_end)
                begin
                    state_next = lmtk_pkg::ST_CLOSE;
                end
            end
            lmtk_pkg::ST_CLOSE:
            begin
                state_next = lmtk_pkg::ST_EMIT;
            end
            lmtk_pkg::ST_EMIT:
            begin
                if (cmd.clear_scan)
                begin
                    state_next = lmtk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lmtk_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmtk_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/lmtk_datapath.sv -----
module lmtk_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [lmtk_pkg::COST_W-1:0]  cfg_data,
    input  lmtk_pkg::in_item_t           sample_item,
    input  lmtk_pkg::cmd_t               cmd,
    output lmtk_pkg::status_t            status,
    output lmtk_pkg::out_item_t          result_item
);

    logic [lmtk_pkg::COST_W-1:0]  ceiling_reg;
    logic [lmtk_pkg::COST_W-1:0]  prev_cost_reg;
    logic [lmtk_pkg::COST_W-1:0]  held_cost_reg;
    logic [lmtk_pkg::INDEX_W-1:0] held_index_reg;
    logic                         held_valid_reg;
    logic [lmtk_pkg::FILL_W-1:0]  fill_reg;
    logic [lmtk_pkg::SCAN_W-1:0]  scan_count_reg;
    logic [lmtk_pkg::RANK_W-1:0]  rank_reg;

    logic [lmtk_pkg::COST_W-1:0]  list_cost_reg  [lmtk_pkg::LIST_DEPTH];
    logic [lmtk_pkg::INDEX_W-1:0] list_index_reg [lmtk_pkg::LIST_DEPTH];

    logic [lmtk_pkg::COST_W-1:0]  next_cost;
    logic                         is_candidate;
    logic                         do_insert;
    logic [lmtk_pkg::LIST_DEPTH-1:0] gt;
    logic                         fits;
    logic [lmtk_pkg::FILL_W-1:0]  rank_ext;

    // Next cost is the incoming sample while streaming, the ceiling at close
    assign next_cost = cmd.close_scan ? ceiling_reg : sample_item.sample_cost;

    assign is_candidate = held_valid_reg
                        && (held_cost_reg < ceiling_reg)
                        && (held_cost_reg < prev_cost_reg)
                        && (held_cost_reg <= next_cost);

    // Each cell flags whether the new candidate goes at or ahead of it;
    // empty cells count as costlier so the flags stay monotonic.
    always_comb
    begin
        for (int i = 0; i < lmtk_pkg::LIST_DEPTH; i++)
        begin
            gt[i] = (lmtk_pkg::FILL_W'(i) >= fill_reg) || (list_cost_reg[i] > held_cost_reg);
        end
    end

    assign fits      = |gt;
    assign do_insert = (cmd.take_sample || cmd.close_scan) && is_candidate && fits;

    assign rank_ext           = lmtk_pkg::FILL_W'(rank_reg);
    assign status.sample_room = (scan_count_reg < lmtk_pkg::SCAN_W'(lmtk_pkg::MAX_SAMPLES));
    assign status.emit_last   = (fill_reg == '0)
                              || (rank_ext == fill_reg - lmtk_pkg::FILL_W'(1));

    always_comb
    begin
        result_item.candidate_sample = (fill_reg == '0) ? '0 : list_index_reg[rank_reg];
        result_item.candidate_rank   = 3'(rank_reg);
        result_item.candidate_count  = 4'(fill_reg);
        result_item.run_last         = status.emit_last;
    end

    // Compare-and-shift row: hold ahead of the slot, drop the candidate in,
    // advance everything behind it by one; the last entry falls off.
    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            for (int i = 0; i < lmtk_pkg::LIST_DEPTH; i++)
            begin
                if (gt[i])
                begin
                    if (i == 0 || !gt[(i > 0) ? i - 1 : 0])
                    begin
                        list_cost_reg[i]  <= held_cost_reg;
                        list_index_reg[i] <= held_index_reg;
                    end
                    else
                    begin
                        list_cost_reg[i]  <= list_cost_reg[(i > 0) ? i - 1 : 0];
                        list_index_reg[i] <= list_index_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_reg    <= lmtk_pkg::CEILING_RESET;
            prev_cost_reg  <= lmtk_pkg::CEILING_RESET;
            held_cost_reg  <= '0;
            held_index_reg <= '0;
            held_valid_reg <= 1'b0;
            fill_reg       <= '0;
            scan_count_reg <= '0;
            rank_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                ceiling_reg <= cfg_data;
            end
            if (do_insert && fill_reg != lmtk_pkg::FILL_W'(lmtk_pkg::LIST_DEPTH))
            begin
                fill_reg <= fill_reg + lmtk_pkg::FILL_W'(1);
            end
            if (cmd.take_sample)
            begin
                if (held_valid_reg)
                begin
                    prev_cost_reg <= held_cost_reg;
                end
                held_cost_reg  <= sample_item.sample_cost;
                held_index_reg <= sample_item.sample_index;
                held_valid_reg <= 1'b1;
                scan_count_reg <= scan_count_reg + lmtk_pkg::SCAN_W'(1);
            end
            if (cmd.clear_scan)
            begin
                rank_reg <= '0;
            end
            else if (cmd.emit_next)
            begin
                rank_reg <= rank_reg + lmtk_pkg::RANK_W'(1);
            end
            if (cmd.clear_scan)
            begin
                prev_cost_reg  <= ceiling_reg;
                held_cost_reg  <= '0;
                held_index_reg <= '0;
                held_valid_reg <= 1'b0;
                fill_reg       <= '0;
                scan_count_reg <= '0;
            end
        end
    end

endmodule

// ----- sv/local_minimum_top_k_selector_core.sv -----
// Streaming top-k local-minimum selector. Each input transaction carries one
// sample cost and its index; the block holds one sample back, keeps it when
// its cost is below cost_ceiling, strictly below the previous cost and no
// greater than the next one, and inserts it (ties in arrival order) into a
// sorted list of the LIST_DEPTH cheapest entries. A transaction with
// stream_end closes the scan and the list comes out one result transaction
// per entry, cheapest first, with run_last on the final one; an empty scan
// gives a single result with count 0. While idle the block accepts a new
// sample without stall, since the row of compare-and-shift cells inserts the
// held candidate in the same cycle the next sample arrives. After a closing
// transaction is accepted, the block judges the last held sample against the
// ceiling, then gives one result per entry (at least one), held by any result
// stall; input stalls then. Write cost_ceiling only while the block is idle.
module local_minimum_top_k_selector_core (
    input  logic                         clk,
    input  logic                         rst_n,

    // configuration write: cost_ceiling
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lmtk_pkg::COST_W-1:0]  cfg_data,

    // sample stream
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  lmtk_pkg::in_item_t           sample_item,

    // candidate results
    output logic                         result_valid,
    input  logic                         result_stall,
    output lmtk_pkg::out_item_t          result_item
);

    lmtk_pkg::cmd_t    cmd;
    lmtk_pkg::status_t status;

    // Ceiling is a plain register; always take the write.
    assign cfg_ready = 1'b1;

    lmtk_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_present (sample_item.sample_present),
        .stream_end     (sample_item.stream_end),
        .sample_stall   (sample_stall),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .status         (status),
        .cmd            (cmd)
    );

    lmtk_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .sample_item (sample_item),
        .cmd         (cmd),
        .status      (status),
        .result_item (result_item)
    );

endmodule
